// ===== design/ibq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibq_pkg
// shared types and constants of the imu biquad filter chain
// ----------------------------------------------------------------------------
package ibq_pkg;

  localparam int AXES_DEF         = 3;
  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int COEF_FRAC_DEF    = 30;

  localparam int LANES      = 3;
  localparam int STAGES     = 7;
  localparam int COEF_COUNT = 35;
  localparam int HIST_DEPTH = 3;
  localparam int DLY_DEPTH  = STAGES * LANES * 2;
  localparam int IDX_W      = 6;

  localparam logic [30:0] SHOCK_RESET = 31'd524288;

  localparam logic [1:0] REQ_SAMPLE   = 2'd0;
  localparam logic [1:0] REQ_COEF     = 2'd1;
  localparam logic [1:0] REQ_RESTART  = 2'd2;
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  localparam logic [1:0] ACC_D1   = 2'd0;
  localparam logic [1:0] ACC_D2   = 2'd1;
  localparam logic [1:0] ACC_SUB  = 2'd2;
  localparam logic [1:0] ACC_TERM = 2'd3;

  localparam logic [2:0] STG_GYRO_LAST   = 3'd4;
  localparam logic [2:0] STG_ACCEL_FIRST = 3'd5;
  localparam logic [2:0] STG_ACCEL_LAST  = 3'd6;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] gyro_x;
    logic signed [31:0] gyro_y;
    logic signed [31:0] gyro_z;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic [5:0]         coef_addr;
    logic signed [31:0] coef_value;
  } ibq_req_t;

  typedef struct packed {
    logic signed [31:0] gyro_x_out;
    logic signed [31:0] gyro_y_out;
    logic signed [31:0] gyro_z_out;
    logic signed [31:0] accel_x_out;
    logic signed [31:0] accel_y_out;
    logic signed [31:0] accel_z_out;
    logic               raw_echo;
  } ibq_res_t;

  typedef struct packed {
    logic             capture;
    logic             coef_wr;
    logic             restart;
    logic             coef_rd;
    logic [IDX_W-1:0] coef_idx;
    logic             dly_rd;
    logic             dly_wr;
    logic [IDX_W-1:0] dly_idx;
    logic             latch_d1;
    logic             latch_d2;
    logic             mul_lo;
    logic             mul_hi;
    logic             mul_src_y;
    logic [1:0]       acc_op;
    logic             y_load;
    logic             x_from_y;
    logic             g_init;
    logic             a_init;
    logic             bypass;
    logic             axis_end;
    logic             active;
    logic             out_load;
    logic             echo_load;
  } ibq_cmd_t;

endpackage

// ===== design/ibq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibq_ctrl
// sequencer: walks axes, stages and the twelve steps of one biquad
// ----------------------------------------------------------------------------
module ibq_ctrl #(
  parameter int AXES = ibq_pkg::AXES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic [1:0]      req_type,
  output logic            req_ready,
  output logic            res_valid,
  input  logic            res_ready,
  output ibq_pkg::ibq_cmd_t cmd
);
  import ibq_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_AX_START = 3'd1;
  localparam logic [2:0] ST_RUN      = 3'd2;
  localparam logic [2:0] ST_A_INIT   = 3'd3;
  localparam logic [2:0] ST_AX_END   = 3'd4;
  localparam logic [2:0] ST_OUT      = 3'd5;
  localparam logic [2:0] ST_ECHO     = 3'd6;

  localparam logic [3:0] STEP_LAST = 4'd11;

  logic [2:0] state, state_next;
  logic [3:0] step;
  logic [2:0] stage;
  logic [1:0] ax;
  logic [1:0] hist_count;
  logic       started;
  logic       accept;
  logic       out_free;
  logic       ax_active;
  logic [2:0] ksel;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign out_free  = !res_valid || res_ready;
  assign ax_active = (32'(ax) < AXES);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && req_type == REQ_SAMPLE) begin
          state_next = started ? ST_AX_START : ST_ECHO;
        end
      end
      ST_AX_START: state_next = ax_active ? ST_RUN : ST_AX_END;
      ST_RUN: begin
        if (step == STEP_LAST) begin
          if (stage == STG_GYRO_LAST) state_next = ST_A_INIT;
          else if (stage == STG_ACCEL_LAST) state_next = ST_AX_END;
        end
      end
      ST_A_INIT: state_next = ST_RUN;
      ST_AX_END: state_next = (ax == 2'(LANES - 1)) ? ST_OUT : ST_AX_START;
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      ST_ECHO:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= '0;
      stage      <= '0;
      ax         <= '0;
      hist_count <= '0;
      started    <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_OUT || state == ST_ECHO) && out_free) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          ax <= '0;
          if (accept && req_type == REQ_RESTART) begin
            hist_count <= '0;
            started    <= 1'b0;
          end
        end
        ST_AX_START: begin
          stage <= '0;
          step  <= '0;
        end
        ST_RUN: begin
          if (step == STEP_LAST) begin
            step  <= '0;
            stage <= stage + 3'd1;
          end else begin
            step <= step + 4'd1;
          end
        end
        ST_A_INIT: begin
          stage <= STG_ACCEL_FIRST;
          step  <= '0;
        end
        ST_AX_END: ax <= ax + 2'd1;
        ST_OUT: begin
          if (out_free) begin
            if (32'(hist_count) < HIST_DEPTH) hist_count <= hist_count + 2'd1;
          end
        end
        ST_ECHO: begin
          if (out_free) begin
            started    <= 1'b1;
            hist_count <= 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd       = '0;
    ksel      = '0;
    cmd.capture = accept;
    cmd.coef_wr = accept && (req_type == REQ_COEF);
    cmd.restart = accept && (req_type == REQ_RESTART);
    cmd.bypass  = (32'(hist_count) < HIST_DEPTH);
    cmd.active  = ax_active;
    case (state)
      ST_AX_START: cmd.g_init = ax_active;
      ST_A_INIT:   cmd.a_init = 1'b1;
      ST_AX_END:   cmd.axis_end = 1'b1;
      ST_OUT:      cmd.out_load = out_free;
      ST_ECHO:     cmd.echo_load = out_free;
      ST_RUN: begin
        case (step)
          4'd0: begin
            cmd.coef_rd = 1'b1;
            cmd.dly_rd  = 1'b1;
          end
          4'd1: begin
            cmd.dly_rd   = 1'b1;
            ksel         = 3'd1;
            cmd.latch_d1 = 1'b1;
            cmd.mul_lo   = 1'b1;
          end
          4'd2: begin
            cmd.latch_d2 = 1'b1;
            cmd.mul_hi   = 1'b1;
            cmd.acc_op   = ACC_D1;
            cmd.coef_rd  = 1'b1;
            ksel         = 3'd1;
          end
          4'd3: begin
            cmd.y_load = 1'b1;
            cmd.mul_lo = 1'b1;
          end
          4'd4: begin
            cmd.mul_hi  = 1'b1;
            cmd.acc_op  = ACC_D2;
            cmd.coef_rd = 1'b1;
            ksel        = 3'd3;
          end
          4'd5: begin
            cmd.mul_lo    = 1'b1;
            cmd.mul_src_y = 1'b1;
          end
          4'd6: begin
            cmd.mul_hi    = 1'b1;
            cmd.mul_src_y = 1'b1;
            cmd.acc_op    = ACC_SUB;
            cmd.coef_rd   = 1'b1;
            ksel          = 3'd2;
          end
          4'd7: begin
            cmd.dly_wr = 1'b1;
            cmd.mul_lo = 1'b1;
          end
          4'd8: begin
            cmd.mul_hi  = 1'b1;
            cmd.acc_op  = ACC_TERM;
            cmd.coef_rd = 1'b1;
            ksel        = 3'd4;
          end
          4'd9: begin
            cmd.mul_lo    = 1'b1;
            cmd.mul_src_y = 1'b1;
          end
          4'd10: begin
            cmd.mul_hi    = 1'b1;
            cmd.mul_src_y = 1'b1;
            cmd.acc_op    = ACC_SUB;
          end
          4'd11: begin
            cmd.dly_wr   = 1'b1;
            ksel         = 3'd1;
            cmd.x_from_y = 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    cmd.coef_idx = IDX_W'(stage) * IDX_W'(5) + IDX_W'(ksel);
    cmd.dly_idx  = (IDX_W'(stage) * IDX_W'(LANES) + IDX_W'(ax)) * IDX_W'(2)
                   + IDX_W'(ksel[0]);
  end

endmodule

// ===== design/ibq_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibq_datapath
// coefficient and delay memories, shared multiply-accumulate, median and clamp
// ----------------------------------------------------------------------------
module ibq_datapath #(
  parameter int AXES           = ibq_pkg::AXES_DEF,
  parameter int SAMPLE_WIDTH   = ibq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = ibq_pkg::COEF_FRAC_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ibq_pkg::ibq_req_t req,
  input  ibq_pkg::ibq_cmd_t cmd,
  input  logic              cfg_valid,
  input  logic [30:0]       cfg_data,
  output ibq_pkg::ibq_res_t res
);
  import ibq_pkg::*;

  localparam int SW   = SAMPLE_WIDTH;
  localparam int DW   = SW + 8;
  localparam int XH_W = SW - 15;
  localparam int PW   = SW + 34;
  localparam int F    = COEF_FRAC_BITS;

  localparam logic signed [PW-1:0] S_MAX = {{(PW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [PW-1:0] D_MAX = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [PW-1:0] O_MAX = {{(PW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [PW-1:0] RND   = {{(PW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

  function automatic logic signed [PW-1:0] clamp(input logic signed [PW-1:0] v,
                                                 input logic signed [PW-1:0] mx);
    logic signed [PW-1:0] r;
    r = v;
    if (v > mx) r = mx;
    else if (v < ~mx) r = ~mx;
    return r;
  endfunction

  function automatic logic signed [31:0] median3(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 input logic signed [31:0] c);
    logic signed [31:0] lo, mid;
    lo  = (a > b) ? b : a;
    mid = (a > b) ? a : b;
    if (mid > c) mid = c;
    if (lo > mid) mid = lo;
    return mid;
  endfunction

  logic signed [31:0]   gin [LANES];
  logic signed [31:0]   ain [LANES];
  logic signed [31:0]   hist [LANES][HIST_DEPTH];
  logic signed [31:0]   rg [LANES];
  logic signed [31:0]   ra [LANES];
  logic [30:0]          shock;
  logic signed [31:0]   coef_mem [COEF_COUNT];
  logic signed [31:0]   coef_q;
  logic [DW-1:0]        dly_mem [DLY_DEPTH];
  logic [DLY_DEPTH-1:0] dly_vld;
  logic [DW-1:0]        dly_q;
  logic signed [DW-1:0] d1r, d2r;
  logic signed [SW-1:0] x, y, gq;
  logic signed [48:0]   plo;
  logic signed [PW-1:0] acc;

  logic signed [SW-1:0]   v;
  logic signed [SW:0]     vext;
  logic signed [XH_W-1:0] xh;
  logic signed [SW+16:0]  phi;
  logic signed [PW-1:0]   full, term, acc_next;
  logic signed [31:0]     amed;
  logic signed [32:0]     a33, lim33, aclp;
  logic signed [PW-1:0]   dnew;

  assign v    = cmd.mul_src_y ? y : x;
  assign vext = {v[SW-1], v};
  assign xh   = $signed(vext[SW:16]);
  assign phi  = coef_q * xh;
  assign full = (PW'(phi) <<< 16) + PW'(plo) + RND;
  assign term = full >>> F;
  assign dnew = clamp(acc, D_MAX);

  always_comb begin
    case (cmd.acc_op)
      ACC_D1:  acc_next = PW'(d1r) + term;
      ACC_D2:  acc_next = PW'(d2r) + term;
      ACC_SUB: acc_next = acc - term;
      default: acc_next = term;
    endcase
  end

  always_comb begin
    amed  = cmd.bypass ? ain[0] : median3(ain[0], hist[0][0], hist[0][1]);
    a33   = 33'(amed);
    lim33 = $signed({2'b00, shock});
    aclp  = a33;
    if (a33 > lim33) aclp = lim33;
    if (a33 < -lim33) aclp = -lim33;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shock <= SHOCK_RESET;
    end else if (cfg_valid) begin
      shock <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.coef_wr && req.coef_addr < IDX_W'(COEF_COUNT)) begin
      coef_mem[req.coef_addr] <= req.coef_value;
    end
    if (cmd.coef_rd) coef_q <= coef_mem[cmd.coef_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.dly_wr) dly_mem[cmd.dly_idx] <= dnew[DW-1:0];
    if (cmd.dly_rd) dly_q <= dly_vld[cmd.dly_idx] ? dly_mem[cmd.dly_idx] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      dly_vld <= '0;
    end else if (cmd.dly_wr) begin
      dly_vld[cmd.dly_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      gin[0] <= req.gyro_x;
      gin[1] <= req.gyro_y;
      gin[2] <= req.gyro_z;
      ain[0] <= req.accel_x;
      ain[1] <= req.accel_y;
      ain[2] <= req.accel_z;
    end else if (cmd.axis_end) begin
      for (int i = 0; i < LANES; i++) begin
        gin[i] <= gin[(i + 1) % LANES];
        ain[i] <= ain[(i + 1) % LANES];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      for (int r = 0; r < LANES; r++) begin
        for (int k = 0; k < HIST_DEPTH; k++) hist[r][k] <= '0;
      end
    end else if (cmd.echo_load) begin
      for (int r = 0; r < LANES; r++) begin
        for (int k = 0; k < HIST_DEPTH; k++) hist[r][k] <= ain[r];
      end
    end else if (cmd.a_init) begin
      hist[0][0] <= ain[0];
      hist[0][1] <= hist[0][0];
      hist[0][2] <= hist[0][1];
    end else if (cmd.axis_end) begin
      for (int r = 0; r < LANES; r++) begin
        for (int k = 0; k < HIST_DEPTH; k++) hist[r][k] <= hist[(r + 1) % LANES][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_d1) d1r <= $signed(dly_q);
    if (cmd.latch_d2) d2r <= $signed(dly_q);
    if (cmd.mul_lo) plo <= coef_q * $signed({1'b0, v[15:0]});
    if (cmd.mul_hi) acc <= acc_next;
    if (cmd.y_load) y <= SW'(clamp(acc, S_MAX));
    if (cmd.g_init) x <= SW'(clamp(PW'(gin[0]), S_MAX));
    else if (cmd.a_init) x <= SW'(clamp(PW'(aclp), S_MAX));
    else if (cmd.x_from_y) x <= y;
    if (cmd.a_init) gq <= y;
    if (cmd.axis_end) begin
      rg[0] <= rg[1];
      rg[1] <= rg[2];
      rg[2] <= cmd.active ? 32'(clamp(PW'(gq), O_MAX)) : '0;
      ra[0] <= ra[1];
      ra[1] <= ra[2];
      ra[2] <= cmd.active ? 32'(clamp(PW'(y), O_MAX)) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res.gyro_x_out  <= rg[0];
      res.gyro_y_out  <= rg[1];
      res.gyro_z_out  <= rg[2];
      res.accel_x_out <= ra[0];
      res.accel_y_out <= ra[1];
      res.accel_z_out <= ra[2];
      res.raw_echo    <= 1'b0;
    end else if (cmd.echo_load) begin
      res.gyro_x_out  <= (AXES > 0) ? gin[0] : '0;
      res.gyro_y_out  <= (AXES > 1) ? gin[1] : '0;
      res.gyro_z_out  <= (AXES > 2) ? gin[2] : '0;
      res.accel_x_out <= (AXES > 0) ? ain[0] : '0;
      res.accel_y_out <= (AXES > 1) ? ain[1] : '0;
      res.accel_z_out <= (AXES > 2) ? ain[2] : '0;
      res.raw_echo    <= 1'b1;
    end
  end

endmodule

// ===== design/imu_biquad_filter_chain_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_biquad_filter_chain_top
// six-axis imu filter chain: gyro biquad cascades, accel median, clamp, biquads
//
//   channel   signals                      word
//   req       req_valid req_ready req      ibq_req_t request
//   res       res_valid res_ready res      ibq_res_t filtered sample
//   cfg       cfg_valid cfg_ready cfg_data shock_limit, always ready
//
// a filtered sample is worked through axis by axis, twelve steps per biquad
// stage, set by the single shared multiply-accumulate unit and the one-port
// delay memory. rst is synchronous; restart clears delays through valid bits
// at once. a new request is taken while a result waits; the next sample
// stalls only at its final output load.
// ----------------------------------------------------------------------------
module imu_biquad_filter_chain_top #(
  parameter int AXES           = ibq_pkg::AXES_DEF,
  parameter int SAMPLE_WIDTH   = ibq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = ibq_pkg::COEF_FRAC_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  ibq_pkg::ibq_req_t req,
  output logic              res_valid,
  input  logic              res_ready,
  output ibq_pkg::ibq_res_t res,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [30:0]       cfg_data
);
  import ibq_pkg::*;

  ibq_cmd_t cmd;

  assign cfg_ready = 1'b1;

  ibq_ctrl #(
    .AXES(AXES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_type (req.req_type),
    .req_ready(req_ready),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .cmd      (cmd)
  );

  ibq_datapath #(
    .AXES          (AXES),
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cmd      (cmd),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .res      (res)
  );

endmodule
